[rtl/assert_macros.svh]
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication outside reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/pcl_pkg.sv]
// package for the chord length parameterization block
// types, constants and state encoding; no dependencies
`timescale 1ns / 1ps
package pcl_pkg;
  localparam int MaxPoints = 64;
  localparam int CoordBits = 24;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = IdxW + 1;
  localparam int LenW = 31;
  localparam int SqW = 2 * CoordBits + 2;
  localparam int RootW = CoordBits + 1;
  localparam int TW = 17;
  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};
  localparam logic [TW-1:0] TOne = TW'(65536);
  localparam logic [1:0] ErrOk = 2'd0;
  localparam logic [1:0] ErrZero = 2'd1;
  localparam logic [1:0] ErrDrop = 2'd2;

  typedef enum logic [2:0] {
    StIdle, StMul, StSqrt, StAcc, StDiv, StOut
  } state_e;

  // serial unit operations
  typedef enum logic [2:0] {
    OpNone, OpMul, OpMac, OpSqrt, OpDiv
  } op_e;

  typedef struct packed {
    logic [IdxW-1:0] vertex_index;
    logic [TW-1:0] param_t;
    logic [LenW-1:0] total_length;
    logic end_of_run;
    logic [1:0] error_code;
  } res_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic final_point;
  } pt_t;
endpackage

[rtl/pcl_stream_if.sv]
// valid/ready vertex request interface
// depends on pcl_pkg
`timescale 1ns / 1ps
interface pcl_in_if;
  logic valid;
  logic ready;
  pcl_pkg::pt_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[rtl/pcl_out_if.sv]
// valid/ready result interface
// depends on pcl_pkg
`timescale 1ns / 1ps
interface pcl_out_if;
  logic valid;
  logic ready;
  pcl_pkg::res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[rtl/pcl_serial_unit.sv]
// shared bit-serial unit: shift-add squaring, restoring square root, restoring divide
// depends on pcl_pkg
`timescale 1ns / 1ps
module pcl_serial_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  pcl_pkg::op_e op_i,
  input  logic start_i,
  input  logic [pcl_pkg::CoordBits:0] ma_i,
  input  logic [pcl_pkg::CoordBits:0] mb_i,
  input  logic [pcl_pkg::LenW-1:0] num_i,
  input  logic [pcl_pkg::LenW-1:0] den_i,
  output logic busy_o,
  output logic [pcl_pkg::RootW-1:0] root_o,
  output logic [pcl_pkg::TW-1:0] quo_o
);
  localparam int AW = pcl_pkg::CoordBits + 1;
  localparam int SqW = pcl_pkg::SqW;
  localparam int RW = pcl_pkg::RootW;
  localparam int NW = pcl_pkg::LenW + 16;
  pcl_pkg::op_e op_q;
  logic [6:0] cnt_q;
  logic [AW-1:0] mb_q;
  logic [SqW-1:0] acc_q, mc_q;
  logic [SqW-1:0] rad_q;
  logic [RW+1:0] rem_q;
  logic [RW-1:0] root_q;
  logic [NW-1:0] num_q;
  logic [pcl_pkg::LenW:0] drem_q;
  logic [pcl_pkg::LenW-1:0] den_q;
  logic [pcl_pkg::TW-1:0] quo_q;
  logic [RW+1:0] trial;
  logic [pcl_pkg::LenW:0] dtrial;
  logic [pcl_pkg::LenW:0] dsh;

  assign trial = {rem_q[RW-1:0], rad_q[SqW-1 -: 2]} - {root_q, 2'b01};
  assign dsh = {drem_q[pcl_pkg::LenW-1:0], num_q[NW-1]};
  assign dtrial = dsh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      op_q <= pcl_pkg::OpNone;
    end else if (start_i) begin
      op_q <= op_i;
      if (op_i == pcl_pkg::OpDiv) cnt_q <= 7'(NW);
      else if (op_i == pcl_pkg::OpSqrt) cnt_q <= 7'(SqW / 2);
      else cnt_q <= 7'(AW);
    end else if (cnt_q != 0) begin
      cnt_q <= cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mb_q <= mb_i;
      mc_q <= SqW'(ma_i);
      // a plain square clears the accumulator, the others keep it
      acc_q <= (op_i == pcl_pkg::OpMul) ? '0 : acc_q;
      rad_q <= acc_q;
      rem_q <= '0;
      root_q <= '0;
      num_q <= {num_i, 16'd0};
      den_q <= den_i;
      drem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != 0) begin
      case (op_q)
        pcl_pkg::OpMul, pcl_pkg::OpMac: begin
          if (mb_q[0]) acc_q <= acc_q + mc_q;
          mb_q <= mb_q >> 1;
          mc_q <= mc_q << 1;
        end
        pcl_pkg::OpSqrt: begin
          rad_q <= rad_q << 2;
          if (!trial[RW+1]) begin
            rem_q <= trial;
            root_q <= {root_q[RW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[RW-1:0], rad_q[SqW-1 -: 2]};
            root_q <= {root_q[RW-2:0], 1'b0};
          end
        end
        pcl_pkg::OpDiv: begin
          num_q <= num_q << 1;
          if (!dtrial[pcl_pkg::LenW]) begin
            drem_q <= dtrial;
            quo_q <= {quo_q[pcl_pkg::TW-2:0], 1'b1};
          end else begin
            drem_q <= dsh;
            quo_q <= {quo_q[pcl_pkg::TW-2:0], 1'b0};
          end
        end
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign busy_o = (cnt_q != 0);
  assign root_o = root_q;
  assign quo_o = quo_q;
endmodule

[rtl/polyline_chord_length_params.sv]
// chord length parameterization of a polyline, top level
// depends on pcl_pkg, pcl_in_if, pcl_out_if, pcl_serial_unit, assert_macros.svh
//
//  channel | dir | payload
//  in_if   | in  | point_x, point_y, final_point
//  out_if  | out | vertex_index, param_t, total_length, end_of_run, error_code
//
// per vertex: two bit-serial squarings and a square root on the shared serial unit,
// 25 steps each; a new request is accepted only once the previous one is done
// the first vertex of a polyline and dropped vertices skip the serial unit
// per result: one 47-step restoring divide; the last vertex and a zero total
// skip the divide
// the cumulative store is a 64 x 31 memory, only entries of the current run are read
// reset clears the control state; a stalled result holds in the output register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module polyline_chord_length_params (
  input logic clk_i,
  input logic rst_ni,
  pcl_in_if.sink in_if,
  pcl_out_if.source out_if
);
  localparam int IdxW = pcl_pkg::IdxW;
  localparam int CntW = pcl_pkg::CntW;
  localparam int LenW = pcl_pkg::LenW;
  localparam int CB = pcl_pkg::CoordBits;

  pcl_pkg::state_e state_q, state_d;
  logic [CB-1:0] px_q, py_q, cx_q, cy_q;
  logic [LenW-1:0] run_q;
  logic [CntW-1:0] cnt_q, oi_q;
  logic ovf_q, last_q, phase_q;
  logic [LenW-1:0] mem [pcl_pkg::MaxPoints];
  logic [LenW-1:0] rd_q;
  logic ov_q;
  pcl_pkg::res_t res_q;

  pcl_pkg::op_e op;
  logic start, busy;
  logic [CB:0] ma;
  logic [pcl_pkg::RootW-1:0] root;
  logic [pcl_pkg::TW-1:0] quo;
  logic [CB:0] dx, dy, adx, ady;
  logic [LenW:0] sum;
  logic accept, isl, tz;

  // magnitudes of the coordinate deltas
  assign dx = {cx_q[CB-1], cx_q} - {px_q[CB-1], px_q};
  assign dy = {cy_q[CB-1], cy_q} - {py_q[CB-1], py_q};
  assign adx = dx[CB] ? -dx : dx;
  assign ady = dy[CB] ? -dy : dy;
  assign ma = phase_q ? ady : adx;
  assign sum = {1'b0, run_q} + (LenW+1)'(root);
  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == pcl_pkg::StIdle);
  assign isl = (oi_q + 1'b1 == cnt_q);
  assign tz = (run_q == '0);

  pcl_serial_unit u_ser (
    .clk_i, .rst_ni, .op_i(op), .start_i(start), .ma_i(ma), .mb_i(ma),
    .num_i(rd_q), .den_i(run_q), .busy_o(busy), .root_o(root), .quo_o(quo)
  );

  always_comb begin
    state_d = state_q;
    start = 1'b0;
    op = pcl_pkg::OpNone;
    case (state_q)
      pcl_pkg::StIdle: if (accept) begin
        if (cnt_q == CntW'(pcl_pkg::MaxPoints) || cnt_q == '0)
          state_d = pcl_pkg::StAcc;
        else begin
          state_d = pcl_pkg::StMul;
        end
      end
      pcl_pkg::StMul: if (!busy) begin
        // dx squared clears the accumulator, dy squared adds to it
        start = 1'b1;
        if (phase_q) begin
          op = pcl_pkg::OpMac;
          state_d = pcl_pkg::StSqrt;
        end else begin
          op = pcl_pkg::OpMul;
        end
      end
      pcl_pkg::StSqrt: if (!busy) begin
        if (phase_q) state_d = pcl_pkg::StAcc;
        else begin
          start = 1'b1;
          op = pcl_pkg::OpSqrt;
        end
      end
      pcl_pkg::StAcc: state_d = last_q ? pcl_pkg::StDiv : pcl_pkg::StIdle;
      pcl_pkg::StDiv: if (!busy && !ov_q) begin
        if (phase_q) state_d = pcl_pkg::StOut;
        else if (!isl && !tz) begin
          start = 1'b1;
          op = pcl_pkg::OpDiv;
        end else state_d = pcl_pkg::StOut;
      end
      pcl_pkg::StOut: if (!ov_q) state_d = (isl) ? pcl_pkg::StIdle : pcl_pkg::StDiv;
      default: state_d = pcl_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcl_pkg::StIdle;
      px_q <= '0; py_q <= '0; run_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
      oi_q <= '0; phase_q <= 1'b0; last_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // output register: loaded in the output state, freed when taken
      if (state_q == pcl_pkg::StOut && !ov_q) ov_q <= 1'b1;
      else if (out_if.ready) ov_q <= 1'b0;
      case (state_q)
        pcl_pkg::StIdle: if (accept) begin
          last_q <= in_if.data.final_point;
          cx_q <= in_if.data.point_x;
          cy_q <= in_if.data.point_y;
          phase_q <= 1'b0;
          if (cnt_q == CntW'(pcl_pkg::MaxPoints)) ovf_q <= 1'b1;
        end
        pcl_pkg::StMul: if (!busy) phase_q <= ~phase_q;
        pcl_pkg::StSqrt: if (!busy && !phase_q) phase_q <= 1'b1;
        pcl_pkg::StAcc: begin
          if (cnt_q != CntW'(pcl_pkg::MaxPoints)) begin
            if (cnt_q != '0) run_q <= sum[LenW] ? pcl_pkg::LenMax : sum[LenW-1:0];
            px_q <= cx_q; py_q <= cy_q;
            cnt_q <= cnt_q + 1'b1;
          end
          phase_q <= 1'b0;
        end
        pcl_pkg::StDiv: if (!busy && !ov_q) begin
          if (!phase_q && !isl && !tz) phase_q <= 1'b1;
        end
        pcl_pkg::StOut: if (!ov_q) begin
          phase_q <= 1'b0;
          // the read index rests at zero between polylines
          if (isl) begin
            oi_q <= '0;
            px_q <= '0; py_q <= '0; run_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
          end else begin
            oi_q <= oi_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // cumulative store and registered read
  always_ff @(posedge clk_i) begin
    if (state_q == pcl_pkg::StAcc && cnt_q != CntW'(pcl_pkg::MaxPoints))
      mem[cnt_q[IdxW-1:0]] <= (cnt_q == '0) ? run_q :
                              (sum[LenW] ? pcl_pkg::LenMax : sum[LenW-1:0]);
    rd_q <= mem[oi_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pcl_pkg::StOut && !ov_q) begin
      res_q.vertex_index <= oi_q[IdxW-1:0];
      res_q.param_t <= tz ? '0 : (isl ? pcl_pkg::TOne : quo);
      res_q.total_length <= run_q;
      res_q.end_of_run <= isl;
      res_q.error_code <= ovf_q ? pcl_pkg::ErrDrop : (tz ? pcl_pkg::ErrZero : pcl_pkg::ErrOk);
    end
  end

  assign out_if.valid = ov_q;
  assign out_if.data = res_q;

  `ASSERT_IMP(a_noin_busy, clk_i, rst_ni, ov_q, !in_if.ready || state_q == pcl_pkg::StIdle)
  `ASSERT_NXT(a_hold, clk_i, rst_ni, ov_q && !out_if.ready, ov_q && $stable(res_q))
  `ASSERT_IMP(a_cnt, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(pcl_pkg::MaxPoints))
endmodule
